[rtl/pcma_pkg.sv]
// package for the pairwise contact map accumulator
// holds payload structs, mode codes and size constants; no dependencies
package pcma_pkg;

    localparam int unsigned MaxBeadsDefault   = 128;
    localparam int unsigned CountWidthDefault = 20;
    localparam int unsigned CoordWidth        = 24;
    localparam int unsigned DistWidth         = 52;
    localparam int unsigned CfgWidth          = 52;
    localparam int unsigned FracWidth         = 17;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    localparam logic CFG_BEAD_COUNT = 1'b0;
    localparam logic CFG_DIST_SQ    = 1'b1;

    typedef struct packed {
        logic [1:0]  mode;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic [6:0]  row_index;
        logic [6:0]  col_index;
    } t_in_item;

    typedef struct packed {
        logic [19:0] pair_count;
        logic [19:0] frame_total;
        logic [16:0] contact_fraction;
    } t_out_item;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
    } t_bead;

    // control handed along the chain with each bead pair
    typedef struct packed {
        logic vld;
    } t_cell_ctl;

endpackage

[rtl/pcma_cell.sv]
// one cell of the pair test chain: squares one axis difference and passes it on
// depends on pcma_pkg
module pcma_cell
    import pcma_pkg::*;
(
    input  logic                        i_clk,
    input  logic signed [CoordWidth-1:0] i_a,
    input  logic signed [CoordWidth-1:0] i_b,
    input  logic [DistWidth+1:0]        i_acc,
    output logic [DistWidth+1:0]        o_acc
);
    logic signed [CoordWidth:0]     w_d;
    logic signed [2*CoordWidth+1:0] w_p;
    logic [2*CoordWidth+1:0]        w_sq;
    logic [DistWidth+1:0]           r_acc;

    assign w_d  = {i_a[CoordWidth-1], i_a} - {i_b[CoordWidth-1], i_b};
    assign w_p  = w_d * w_d;
    assign w_sq = $unsigned(w_p);

    always_ff @(posedge i_clk) begin
        r_acc <= i_acc + (DistWidth+2)'(w_sq);
    end

    assign o_acc = r_acc;
endmodule

[rtl/pcma_divider.sv]
// restoring divider for the contact fraction, one quotient bit per cycle
// depends on pcma_pkg
module pcma_divider
    import pcma_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = CountWidthDefault
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [COUNT_WIDTH-1:0] i_num,
    input  logic [COUNT_WIDTH-1:0] i_den,
    output logic                   o_done,
    output logic [FracWidth-1:0]   o_quot
);
    localparam int unsigned NW = COUNT_WIDTH + 16;
    localparam int unsigned CW = $clog2(NW + 1);

    logic [NW-1:0]        r_num;
    logic [COUNT_WIDTH:0] r_rem;
    logic [NW-1:0]        r_q;
    logic [COUNT_WIDTH-1:0] r_den;
    logic [CW-1:0]        r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [COUNT_WIDTH+1:0] w_try;

    assign w_try = {r_rem, r_num[NW-1]} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_num  <= {i_num, 16'd0};
                r_rem  <= '0;
                r_q    <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_num <= r_num << 1;
                if (!w_try[COUNT_WIDTH+1]) begin
                    r_rem <= w_try[COUNT_WIDTH:0];
                    r_q   <= {r_q[NW-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[COUNT_WIDTH-1:0], r_num[NW-1]};
                    r_q   <= {r_q[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = (r_den == '0) ? '0 :
                    (r_q > NW'(65536)) ? FracWidth'(65536) : FracWidth'(r_q);
endmodule

[rtl/pairwise_contact_map_accumulator_top.sv]
// Loads one bead per load transaction into a bead store. When a frame fills,
// the block runs a pass: for each pivot bead i, every bead j streams from the
// store through a chain of three cells (one per axis), and each pair whose
// squared distance is below the threshold increments its count memory entry
// by read-modify-write. A read computes its fraction with the one-bit-per-cycle
// fraction divider. After reset and after each clear transaction, a clearing
// pass sweeps every count memory entry while no input transaction is taken.
// Depends on pcma_pkg.
module pairwise_contact_map_accumulator_top
    import pcma_pkg::*;
#(
    parameter int unsigned MAX_BEADS   = MaxBeadsDefault,
    parameter int unsigned COUNT_WIDTH = CountWidthDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  t_in_item            i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output t_out_item           o_data,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [CfgWidth-1:0] i_cfg_data
);
    localparam int unsigned BW = $clog2(MAX_BEADS);
    localparam int unsigned AW = 2 * BW;
    localparam int unsigned NW = $clog2(MAX_BEADS + 1);
    localparam int unsigned PIPE = 5;
    localparam logic [COUNT_WIDTH-1:0] CntMax = '1;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_FRAME = 6'b000100,
        ST_RDMEM = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

    t_state r_state;
    logic [7:0]           r_bead_count;
    logic [DistWidth-1:0] r_dist_sq;
    logic [NW-1:0]        r_fill;
    logic [COUNT_WIDTH-1:0] r_frames;
    logic [AW-1:0]        r_clr_addr;
    logic [BW-1:0]        r_i;
    logic [NW-1:0]        r_j;
    logic                 r_issue_done;
    logic [BW-1:0]        r_rd_addr;
    logic [COUNT_WIDTH-1:0] r_rd_cnt;
    logic                 r_rd_zero;
    t_out_item            r_out;
    logic                 r_out_vld;
    logic                 r_div_start;

    t_bead                bead_mem [MAX_BEADS];
    logic [COUNT_WIDTH-1:0] cnt_mem [2**AW];

    t_bead                r_pivot;
    t_bead                r_bj;
    t_bead                r_pv0;
    t_bead                r_bj1, r_bj2;
    t_bead                r_pv1, r_pv2;
    t_cell_ctl            r_ctl [PIPE];
    logic [AW-1:0]        r_pa  [PIPE];
    logic [COUNT_WIDTH-1:0] r_cnt_q;
    logic                 r_hit;
    logic [DistWidth+1:0] w_acc0, w_accy, w_accz;
    logic [NW-1:0]        w_n;
    logic [NW-1:0]        w_fill_nx;
    logic                 w_frame_go;
    logic                 w_in_acc;
    logic                 w_div_done;
    logic [FracWidth-1:0] w_quot;
    logic                 w_cnt_we;
    logic [AW-1:0]        w_cnt_waddr;
    logic [COUNT_WIDTH-1:0] w_cnt_wdata;
    logic [AW-1:0]        w_cnt_raddr;
    logic [BW-1:0]        w_bead_raddr;

    always_comb begin
        if (r_bead_count < 8'd2) w_n = NW'(2);
        else if (NW'(r_bead_count) > NW'(MAX_BEADS) || 32'(r_bead_count) > MAX_BEADS)
            w_n = NW'(MAX_BEADS);
        else w_n = NW'(r_bead_count);
    end

    assign o_stall  = (r_state != ST_IDLE) || r_out_vld;
    assign w_in_acc = i_valid && !o_stall;
    assign w_fill_nx = (r_fill >= NW'(MAX_BEADS)) ? NW'(MAX_BEADS) : r_fill + 1'b1;
    assign w_frame_go = w_in_acc && t_mode'(i_data.mode) == MODE_LOAD && w_fill_nx >= w_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bead_count <= 8'd100;
            r_dist_sq    <= DistWidth'(104857600);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BEAD_COUNT: r_bead_count <= i_cfg_data[7:0];
                CFG_DIST_SQ:    r_dist_sq    <= i_cfg_data[DistWidth-1:0];
                default: ;
            endcase
        end
    end

    // bead store
    assign w_bead_raddr = r_j[BW-1:0];
    always_ff @(posedge i_clk) begin
        if (w_in_acc && t_mode'(i_data.mode) == MODE_LOAD) begin
            bead_mem[(r_fill >= NW'(MAX_BEADS)) ? BW'(MAX_BEADS-1) : r_fill[BW-1:0]]
                <= '{x: i_data.pos_x, y: i_data.pos_y, z: i_data.pos_z};
        end
        r_bj  <= bead_mem[w_bead_raddr];
        r_pv0 <= r_pivot;
    end

    // the y and z cells sit further down the chain; hold delayed copies aligned
    always_ff @(posedge i_clk) begin
        r_bj1 <= r_bj; r_bj2 <= r_bj1;
        r_pv1 <= r_pv0; r_pv2 <= r_pv1;
    end

    // chain of axis cells
    pcma_cell u_cell_x (.i_clk, .i_a(r_bj.x), .i_b(r_pv0.x), .i_acc('0), .o_acc(w_acc0));
    pcma_cell u_cell_y (.i_clk, .i_a(r_bj1.y), .i_b(r_pv1.y), .i_acc(w_acc0), .o_acc(w_accy));
    pcma_cell u_cell_z (.i_clk, .i_a(r_bj2.z), .i_b(r_pv2.z), .i_acc(w_accy), .o_acc(w_accz));

    always_ff @(posedge i_clk) begin
        r_hit <= (w_accz < {2'b00, r_dist_sq});
    end

    // count memory
    assign w_cnt_raddr = (r_state == ST_FRAME) ? r_pa[3] : {r_rd_addr, r_i};
    always_comb begin
        w_cnt_we    = 1'b0;
        w_cnt_waddr = r_pa[4];
        w_cnt_wdata = (r_cnt_q == CntMax) ? CntMax : r_cnt_q + 1'b1;
        if (r_state == ST_CLEAR) begin
            w_cnt_we    = 1'b1;
            w_cnt_waddr = r_clr_addr;
            w_cnt_wdata = '0;
        end else if (r_ctl[4].vld && r_hit) begin
            w_cnt_we = 1'b1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_cnt_we) cnt_mem[w_cnt_waddr] <= w_cnt_wdata;
        r_cnt_q <= cnt_mem[w_cnt_raddr];
    end

    // pipeline tags: stage 0 bead read, 1..3 cells, 4 compare and write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PIPE; k++) r_ctl[k] <= '0;
        end else begin
            r_ctl[0].vld <= (r_state == ST_FRAME) && !r_issue_done;
            for (int k = 1; k < PIPE; k++) r_ctl[k] <= r_ctl[k-1];
        end
    end
    always_ff @(posedge i_clk) begin
        r_pa[0] <= {r_i, r_j[BW-1:0]};
        for (int k = 1; k < PIPE; k++) r_pa[k] <= r_pa[k-1];
    end

    pcma_divider #(.COUNT_WIDTH(COUNT_WIDTH)) u_div (
        .i_clk, .i_rst_n, .i_start(r_div_start),
        .i_num(r_rd_cnt), .i_den(r_frames), .o_done(w_div_done), .o_quot(w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_fill       <= '0;
            r_frames     <= '0;
            r_out_vld    <= 1'b0;
            r_div_start  <= 1'b0;
            r_issue_done <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (r_out_vld && !i_stall) r_out_vld <= 1'b0;
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == '1) r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (w_in_acc) begin
                        unique case (t_mode'(i_data.mode))
                            MODE_LOAD: begin
                                if (w_frame_go) begin
                                    r_fill       <= '0;
                                    r_i          <= '0;
                                    r_j          <= '0;
                                    r_issue_done <= 1'b0;
                                    r_state      <= ST_FRAME;
                                end else begin
                                    r_fill <= w_fill_nx;
                                end
                            end
                            MODE_READ: begin
                                r_rd_addr <= BW'(i_data.row_index);
                                r_i       <= BW'(i_data.col_index);
                                r_rd_zero <= (32'(i_data.row_index) >= MAX_BEADS) ||
                                             (32'(i_data.col_index) >= MAX_BEADS);
                                r_state   <= ST_RDMEM;
                            end
                            MODE_CLEAR: begin
                                r_fill     <= '0;
                                r_frames   <= '0;
                                r_clr_addr <= '0;
                                r_state    <= ST_CLEAR;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_FRAME: begin
                    if (!r_issue_done) begin
                        if (r_j == w_n - 1'b1) begin
                            r_j <= '0;
                            if (NW'(r_i) == w_n - 1'b1) r_issue_done <= 1'b1;
                            else begin
                                r_i <= r_i + 1'b1;
                            end
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end else if (!r_ctl[0].vld && !r_ctl[1].vld && !r_ctl[2].vld &&
                                 !r_ctl[3].vld && !r_ctl[4].vld) begin
                        r_frames <= (r_frames == CntMax) ? CntMax : r_frames + 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                ST_RDMEM: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (!r_div_start && !w_div_done && r_clr_addr == '0) begin
                        r_rd_cnt    <= r_rd_zero ? '0 : r_cnt_q;
                        r_div_start <= 1'b1;
                        r_clr_addr  <= AW'(1);
                    end else if (w_div_done) begin
                        r_clr_addr <= '0;
                        r_out.pair_count       <= 20'(r_rd_cnt);
                        r_out.frame_total      <= 20'(r_frames);
                        r_out.contact_fraction <= w_quot;
                        r_out_vld <= 1'b1;
                        r_state   <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // pivot loads at frame start and moves when pair issue reaches a new row
    always_ff @(posedge i_clk) begin
        if (w_frame_go)
            r_pivot <= bead_mem[0];
        else if (r_state == ST_FRAME && !r_issue_done && r_j == w_n - 1'b1 &&
                 NW'(r_i) != w_n - 1'b1)
            r_pivot <= bead_mem[r_i + 1'b1];
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> o_stall)
        else $error("input taken during clearing pass");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.contact_fraction <= FracWidth'(65536)))
        else $error("fraction above one");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.frame_total == '0) |-> (o_data.contact_fraction == '0))
        else $error("nonzero fraction with no frames");
endmodule
